FILE: hdl/imupd_pkg.sv
package imupd_pkg;

  localparam int BYTE_W     = 8;
  localparam int AXIS_W     = 19;
  localparam int POS_W      = 5;
  localparam int STORE_N    = 19;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  // header flag bits
  localparam int HDR_EMPTY_BIT = 7;
  localparam int HDR_ACCEL_BIT = 6;
  localparam int HDR_GYRO_BIT  = 5;
  localparam int HDR_HIRES_BIT = 4;

  // packet lengths in bytes, header included
  localparam logic [POS_W:0] LEN_HIRES = 6'd20;
  localparam logic [POS_W:0] LEN_BOTH  = 6'd16;
  localparam logic [POS_W:0] LEN_ONE   = 6'd8;

  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_GYRO  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t pkt_store_t [STORE_N];
  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic  kind;
    axis_t x;
    axis_t y;
    axis_t z;
    logic  ext;
    logic  last;
  } sample_t;

  // Assemble one axis: little-endian 16-bit value, optionally widened with
  // extension bits (2 low bits for the accelerometer, 3 for the gyro).
  function automatic axis_t axis_value(byte_t lo, byte_t hi, byte_t ext_b,
                                       logic hires, logic gyro);
    logic [15:0] raw;
    axis_t       v;
    raw = {hi, lo};
    if (!hires) begin
      v = {{(AXIS_W-16){raw[15]}}, raw};
    end else if (gyro) begin
      v = {raw, ext_b[3:1]};
    end else begin
      v = {raw[15], raw, ext_b[7:6]};
    end
    return v;
  endfunction

endpackage

FILE: hdl/imupd_unpack.sv
module imupd_unpack
  import imupd_pkg::*;
(
  input  byte_t      header,
  input  pkt_store_t pkt,
  output sample_t    res [2],
  output logic [1:0] res_n
);

  logic    has_a;
  logic    has_g;
  logic    hires;
  sample_t accel;
  sample_t gyro;

  always_comb begin
    has_a = header[HDR_ACCEL_BIT];
    has_g = header[HDR_GYRO_BIT];
    hires = header[HDR_HIRES_BIT];

    accel.kind = KIND_ACCEL;
    accel.x    = axis_value(pkt[0], pkt[1], pkt[16], hires, 1'b0);
    accel.y    = axis_value(pkt[2], pkt[3], pkt[17], hires, 1'b0);
    accel.z    = axis_value(pkt[4], pkt[5], pkt[18], hires, 1'b0);
    accel.ext  = hires;
    accel.last = !has_g;

    // gyro follows the accelerometer block when both are present
    gyro.kind = KIND_GYRO;
    if (has_a) begin
      gyro.x = axis_value(pkt[6],  pkt[7],  pkt[16], hires, 1'b1);
      gyro.y = axis_value(pkt[8],  pkt[9],  pkt[17], hires, 1'b1);
      gyro.z = axis_value(pkt[10], pkt[11], pkt[18], hires, 1'b1);
    end else begin
      gyro.x = axis_value(pkt[0], pkt[1], pkt[16], hires, 1'b1);
      gyro.y = axis_value(pkt[2], pkt[3], pkt[17], hires, 1'b1);
      gyro.z = axis_value(pkt[4], pkt[5], pkt[18], hires, 1'b1);
    end
    gyro.ext  = hires;
    gyro.last = 1'b1;

    res[0] = has_a ? accel : gyro;
    res[1] = gyro;
    res_n  = {1'b0, has_a} + {1'b0, has_g};
  end

endmodule

FILE: hdl/imu_fifo_packet_decoder.sv
// Sensor FIFO packet decoder.
// Input channel (in_*): one FIFO byte per transfer in in_tdata[7:0]; in_tlast
// marks the last byte of a readout and sends the parser back to expecting a
// header (a packet cut short there is dropped without results).
// Output channel (out_*): one sample per transfer; accelerometer before gyro,
// out_tlast on the final sample of a packet, out_tuser[0] gives the kind.
// A completed packet yields zero, one or two samples.
// Throughput: one byte per cycle while in_tready is high. The samples of a
// packet enter the result queue as its final byte is transferred.
// Samples wait in a four-entry result queue; the input takes a byte whenever
// the queue has room for two samples, so a stalled receiver holds in_tready
// low only once more than two samples are waiting.
// Reset (rst_n low, synchronous) clears the parser position, header and the
// result queue; the parser then expects a header byte.
module imu_fifo_packet_decoder
  import imupd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [18:0] axis_x, [37:19] axis_y, [56:38] axis_z, rest 0
  output logic [1:0]  out_tuser,  // [0] sample_kind, [1] extended
  output logic        out_tlast   // last_in_packet
);

  // parser state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  byte_t              hdr_r, hdr_nxt;
  pkt_store_t         pkt_r;
  pkt_store_t         pkt_view;

  // result queue
  sample_t            q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_CW-1:0] cnt_r, cnt_nxt;

  logic               in_xfer;
  logic               out_xfer;
  logic               store_byte;
  logic [POS_W:0]     pkt_len;
  logic               pkt_done;
  sample_t            res [2];
  logic [1:0]         res_n;
  logic [1:0]         push_n;
  sample_t            head;

  assign in_tready = (cnt_r <= OUTQ_CW'(OUTQ_DEPTH - 2));
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  assign store_byte = in_xfer && (pos_r != '0);

  always_comb begin
    if (hdr_r[HDR_HIRES_BIT]) begin
      pkt_len = LEN_HIRES;
    end else if (hdr_r[HDR_ACCEL_BIT] && hdr_r[HDR_GYRO_BIT]) begin
      pkt_len = LEN_BOTH;
    end else begin
      pkt_len = LEN_ONE;
    end
  end

  assign pkt_done = store_byte && (({1'b0, pos_r} + 6'd1) >= pkt_len);

  // route the byte being written straight into the decode view
  always_comb begin
    for (int i = 0; i < STORE_N; i++) begin
      if (store_byte && (pos_r == POS_W'(i + 1))) begin
        pkt_view[i] = in_tdata;
      end else begin
        pkt_view[i] = pkt_r[i];
      end
    end
  end

  imupd_unpack u_unpack (
    .header (hdr_r),
    .pkt    (pkt_view),
    .res    (res),
    .res_n  (res_n)
  );

  // next parser position: skip empty headers, advance inside a packet,
  // drop back to header hunt on completion or end of readout
  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    if (in_xfer) begin
      if (pos_r == '0) begin
        if (!in_tdata[HDR_EMPTY_BIT]) begin
          hdr_nxt = in_tdata;
          pos_nxt = POS_W'(1);
        end
      end else if (pkt_done) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (in_tlast) begin
        pos_nxt = '0;
      end
    end
  end

  assign push_n     = pkt_done ? res_n : 2'd0;
  assign wr_ptr_nxt = wr_ptr_r + OUTQ_AW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + OUTQ_AW'(out_xfer);
  assign cnt_nxt    = cnt_r + OUTQ_CW'(push_n) - OUTQ_CW'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      hdr_r    <= hdr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // packet byte store and queue payload: no reset needed
  always_ff @(posedge clk) begin
    pkt_r <= pkt_view;
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res[0];
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + OUTQ_AW'(1)] <= res[1];
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {7'd0, head.z, head.y, head.x};
  assign out_tuser  = {head.ext, head.kind};
  assign out_tlast  = head.last;

endmodule

FILE: dv/imupd_sample_checker.sv
// Watches both streams of the packet decoder, predicts the samples that each
// accepted FIFO byte yields, and compares every sample transfer against the
// oldest prediction still waiting.
module imupd_sample_checker
  import imupd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          pending
);

  localparam byte_t GYRO_EXT_MASK = 8'h0e;
  localparam int    SAMPLE_BYTES  = 6;
  localparam int    EXT_X         = 17;
  localparam int    EXT_Y         = 18;
  localparam int    EXT_Z         = 19;
  localparam int    REPORT_MAX    = 10;

  logic [POS_W-1:0] byte_pos;
  byte_t            cur_header;
  byte_t            pkt_bytes [1:STORE_N];
  sample_t          samples_due [$];
  int               reported;

  // 16-bit little-endian axis, widened by the packet's extension bits
  function automatic axis_t widen_axis(byte_t lo, byte_t hi, byte_t ext_b,
                                       logic hires, logic gyro);
    int v;
    v = int'($signed({hi, lo}));
    if (hires && gyro) begin
      v = v * 8 + int'((ext_b & GYRO_EXT_MASK) >> 1);
    end else if (hires) begin
      v = v * 4 + int'(ext_b >> 6);
    end
    return axis_t'(v);
  endfunction

  function automatic sample_t make_sample(logic kind, int first, logic last);
    sample_t s;
    logic    hires;
    logic    gyro;
    hires  = cur_header[HDR_HIRES_BIT];
    gyro   = (kind == KIND_GYRO);
    s.kind = kind;
    s.x    = widen_axis(pkt_bytes[first], pkt_bytes[first+1], pkt_bytes[EXT_X], hires, gyro);
    s.y    = widen_axis(pkt_bytes[first+2], pkt_bytes[first+3], pkt_bytes[EXT_Y], hires, gyro);
    s.z    = widen_axis(pkt_bytes[first+4], pkt_bytes[first+5], pkt_bytes[EXT_Z], hires, gyro);
    s.ext  = hires;
    s.last = last;
    return s;
  endfunction

  // advance the packet parser by one FIFO byte, queue the samples it completes
  task automatic decode_byte(byte_t b, logic eob);
    int len;
    int first;
    if (byte_pos == '0) begin
      if (!b[HDR_EMPTY_BIT]) begin
        cur_header = b;
        byte_pos   = POS_W'(1);
      end
    end else begin
      pkt_bytes[byte_pos] = b;
      if (cur_header[HDR_HIRES_BIT]) begin
        len = int'(LEN_HIRES);
      end else if (cur_header[HDR_ACCEL_BIT] && cur_header[HDR_GYRO_BIT]) begin
        len = int'(LEN_BOTH);
      end else begin
        len = int'(LEN_ONE);
      end
      if (int'(byte_pos) + 1 >= len) begin
        first = 1;
        if (cur_header[HDR_ACCEL_BIT]) begin
          samples_due.push_back(make_sample(KIND_ACCEL, first, !cur_header[HDR_GYRO_BIT]));
          first += SAMPLE_BYTES;
        end
        if (cur_header[HDR_GYRO_BIT]) begin
          samples_due.push_back(make_sample(KIND_GYRO, first, 1'b1));
        end
        byte_pos = '0;
      end else begin
        byte_pos = byte_pos + POS_W'(1);
      end
    end
    if (eob) begin
      byte_pos = '0;
    end
  endtask

  task automatic check_sample(sample_t got, logic [6:0] pad);
    sample_t want;
    if (samples_due.size() == 0) begin
      errors++;
      if (reported < REPORT_MAX) begin
        $display("%0t unexpected sample: kind=%0d x=%0d y=%0d z=%0d ext=%0d last=%0d",
                 $realtime, got.kind, got.x, got.y, got.z, got.ext, got.last);
      end
      reported++;
    end else begin
      want = samples_due.pop_front();
      if (got !== want || pad !== '0) begin
        errors++;
        if (reported < REPORT_MAX) begin
          $display("%0t sample mismatch: exp kind=%0d x=%0d y=%0d z=%0d ext=%0d last=%0d",
                   $realtime, want.kind, want.x, want.y, want.z, want.ext, want.last);
          $display("%0t                  got kind=%0d x=%0d y=%0d z=%0d ext=%0d last=%0d pad=%h",
                   $realtime, got.kind, got.x, got.y, got.z, got.ext, got.last, pad);
        end
        reported++;
      end
    end
  endtask

  always @(posedge clk) begin
    sample_t got;
    if (!rst_n) begin
      byte_pos   = '0;
      cur_header = '0;
      samples_due.delete();
      errors     = 0;
      reported   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser[0];
        got.x    = out_tdata[18:0];
        got.y    = out_tdata[37:19];
        got.z    = out_tdata[56:38];
        got.ext  = out_tuser[1];
        got.last = out_tlast;
        check_sample(got, out_tdata[63:57]);
      end
    end
    pending = samples_due.size();
  end

endmodule

FILE: dv/tb_top.sv
// Drives FIFO byte streams into the packet decoder and throttles the sample
// stream; the checker beside the block predicts and compares.
module tb_top;
  import imupd_pkg::*;

  localparam int ITEMS      = 800;
  localparam int QUIET_FROM = 640;   // no idling on either side from here on
  localparam int IDLE_LIMIT = 1000;  // cycles without any transfer
  localparam int DRAIN      = 16;
  localparam int EXT_FIRST  = 17;

  typedef enum {FILL_RAND, FILL_NEG, FILL_POS, FILL_ONES} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int   errors;
  int   pending;
  int   bytes_sent;
  int   idle_cycles;
  logic quiet;

  imu_fifo_packet_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  imupd_sample_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run once nothing has moved for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sample receiver: stall in bursts of random length until the quiet tail.
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Send one byte; optionally open a gap first, then hold until the transfer.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (bytes_sent >= QUIET_FROM) begin
      quiet = 1'b1;
    end
  endtask

  // Send a header and its packet body. cut_at >= 0 ends the readout on that
  // byte if in the packet (0 = on the header itself); eob_end marks the last byte.
  task automatic send_packet(logic [7:0] hdr, fill_t fill, int cut_at, logic eob_end);
    int         len;
    logic [7:0] b;
    if (hdr[HDR_HIRES_BIT]) begin
      len = int'(LEN_HIRES);
    end else if (hdr[HDR_ACCEL_BIT] && hdr[HDR_GYRO_BIT]) begin
      len = int'(LEN_BOTH);
    end else begin
      len = int'(LEN_ONE);
    end
    send_byte(hdr, cut_at == 0);
    if (cut_at == 0) begin
      return;
    end
    for (int k = 1; k < len; k++) begin
      case (fill)
        FILL_RAND: b = 8'($urandom);
        FILL_ONES: b = '1;
        // most negative axis values, extension bits clear
        FILL_NEG:  b = (k >= EXT_FIRST) ? 8'h00 : ((k % 2) ? 8'h00 : 8'h80);
        // most positive axis values, extension bits set
        default:   b = (k >= EXT_FIRST) ? 8'hff : ((k % 2) ? 8'hff : 8'h7f);
      endcase
      if (k == cut_at) begin
        send_byte(b, 1'b1);
        return;
      end
      send_byte(b, (k == len - 1) && eob_end);
    end
  endtask

  initial begin
    int         pick;
    logic [7:0] hdr;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    quiet      = 1'b0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty headers, every flag mix, axis extremes, cut packets.
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b1);
    send_packet(8'h40, FILL_NEG,  -1, 1'b0);   // accel only
    send_packet(8'h20, FILL_POS,  -1, 1'b1);   // gyro only, readout ends on it
    send_packet(8'h60, FILL_ONES, -1, 1'b0);   // both samples
    send_packet(8'h70, FILL_POS,  -1, 1'b0);   // both, high resolution
    send_packet(8'h70, FILL_NEG,  -1, 1'b0);
    send_packet(8'h50, FILL_RAND, -1, 1'b0);   // accel only, high resolution
    send_packet(8'h3f, FILL_RAND, -1, 1'b0);   // gyro only, high resolution
    send_packet(8'h0f, FILL_RAND, -1, 1'b0);   // no sample flags
    send_packet(8'h1f, FILL_RAND, -1, 1'b0);   // no sample flags, long packet
    send_packet(8'h60, FILL_RAND,  9, 1'b0);   // cut short mid-packet
    send_packet(8'h40, FILL_RAND,  0, 1'b0);   // readout ends on the header
    send_packet(8'h40, FILL_POS,  -1, 1'b0);

    // Random: mostly well-formed packets, some empty headers, cuts and noise.
    while (bytes_sent < ITEMS) begin
      pick = $urandom_range(0, 19);
      hdr  = {1'b0, 7'($urandom)};
      if (pick < 14) begin
        send_packet(hdr, FILL_RAND, -1, $urandom_range(0, 3) == 0);
      end else if (pick < 16) begin
        send_byte({1'b1, 7'($urandom)}, $urandom_range(0, 3) == 0);
      end else if (pick < 18) begin
        send_packet(hdr, FILL_RAND, $urandom_range(0, 18), 1'b0);
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
